// ===== design/config_bitstream_crc16_check_top_defines.svh =====
// Assertion macros shared by the checker modules.
`ifndef CONFIG_BITSTREAM_CRC16_CHECK_TOP_DEFINES_SVH
`define CONFIG_BITSTREAM_CRC16_CHECK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CBCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/cbcc_pkg.sv =====
package cbcc_pkg;

  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned COUNT_W     = 27;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8005;
  localparam logic [WORD_W-1:0] RESET_CMD = 32'd7;
  localparam logic [ADDR_W-1:0] ADDR_CRC  = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_CMD  = 5'd4;

  typedef enum logic [OP_W-1:0] {
    OP_TYPE1   = 2'd0,
    OP_TYPE2   = 2'd1,
    OP_PAYLOAD = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_UNDECIDED = 2'd0,
    ACT_FOLD      = 2'd1,
    ACT_IGNORE    = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    CMD_FOLD      = 2'd0,
    CMD_FOLD_AUTO = 2'd1,
    CMD_CHECK     = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_CHECK = 1'b0,
    KIND_AUTO  = 1'b1
  } kind_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } cmd_entry_t;

  // One CRC step per input bit, MSB-first register, no input reflection.
  function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc, input logic b);
    logic fb;
    fb = crc[CRC_W-1] ^ b;
    return {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
  endfunction

  // Folds the data word and then the address, both LSB first.
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                input logic [WORD_W-1:0] word,
                                                input logic [ADDR_W-1:0] addr);
    logic [CRC_W-1:0] c;
    c = crc;
    for (int i = 0; i < WORD_W; i++) begin
      c = crc_bit(c, word[i]);
    end
    for (int i = 0; i < ADDR_W; i++) begin
      c = crc_bit(c, addr[i]);
    end
    return c;
  endfunction

  function automatic logic [CRC_W-1:0] reflect16(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== design/cbcc_front.sv =====
module cbcc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 item_accept,
  input  cbcc_pkg::op_t                        op,
  input  logic [cbcc_pkg::ADDR_W-1:0]          reg_address,
  input  logic [cbcc_pkg::COUNT_W-1:0]         word_count,
  input  logic [cbcc_pkg::WORD_W-1:0]          data_word,
  output logic                                 push,
  output cbcc_pkg::cmd_entry_t                 push_entry
);

  `include "config_bitstream_crc16_check_top_defines.svh"

  logic [cbcc_pkg::ADDR_W-1:0]  cur_addr_r, cur_addr_nxt;
  logic [cbcc_pkg::COUNT_W-1:0] words_left_r, words_left_nxt;
  cbcc_pkg::act_t               action_r, action_nxt;
  logic                         is_type2_r, is_type2_nxt;
  logic                         at_first_r, at_first_nxt;

  always_comb begin
    cbcc_pkg::act_t act;
    cur_addr_nxt     = cur_addr_r;
    words_left_nxt   = words_left_r;
    action_nxt       = action_r;
    is_type2_nxt     = is_type2_r;
    at_first_nxt     = at_first_r;
    push             = 1'b0;
    push_entry.cmd   = cbcc_pkg::CMD_FOLD;
    push_entry.addr  = cur_addr_r;
    push_entry.word  = data_word;
    act              = action_r;
    if (item_accept) begin
      case (op)
        cbcc_pkg::OP_TYPE1, cbcc_pkg::OP_TYPE2: begin
          if (op == cbcc_pkg::OP_TYPE1) begin
            cur_addr_nxt = reg_address;
          end
          is_type2_nxt   = (op == cbcc_pkg::OP_TYPE2);
          words_left_nxt = word_count;
          at_first_nxt   = (word_count != '0);
          action_nxt     = cbcc_pkg::ACT_UNDECIDED;
        end
        cbcc_pkg::OP_PAYLOAD: begin
          if (words_left_r != '0) begin
            // The first word of a packet decides what the rest of it does.
            if (at_first_r) begin
              at_first_nxt = 1'b0;
              if (cur_addr_r == cbcc_pkg::ADDR_CRC) begin
                act            = cbcc_pkg::ACT_IGNORE;
                push           = 1'b1;
                push_entry.cmd = cbcc_pkg::CMD_CHECK;
              end else if (cur_addr_r == cbcc_pkg::ADDR_CMD &&
                           data_word == cbcc_pkg::RESET_CMD) begin
                act            = cbcc_pkg::ACT_IGNORE;
                push           = 1'b1;
                push_entry.cmd = cbcc_pkg::CMD_CLEAR;
              end else begin
                act = cbcc_pkg::ACT_FOLD;
              end
            end
            if (act == cbcc_pkg::ACT_FOLD) begin
              push           = 1'b1;
              push_entry.cmd = (is_type2_r && words_left_r == cbcc_pkg::COUNT_W'(1)) ?
                               cbcc_pkg::CMD_FOLD_AUTO : cbcc_pkg::CMD_FOLD;
            end
            action_nxt     = act;
            words_left_nxt = words_left_r - cbcc_pkg::COUNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_addr_r   <= '0;
      words_left_r <= '0;
      action_r     <= cbcc_pkg::ACT_UNDECIDED;
      is_type2_r   <= 1'b0;
      at_first_r   <= 1'b0;
    end else begin
      cur_addr_r   <= cur_addr_nxt;
      words_left_r <= words_left_nxt;
      action_r     <= action_nxt;
      is_type2_r   <= is_type2_nxt;
      at_first_r   <= at_first_nxt;
    end
  end

  `CBCC_ASSERT(a_first_needs_words, clk, rst_n, at_first_r |-> (words_left_r != '0), "first-word flag set with no words left")

endmodule

// ===== design/cbcc_queue.sv =====
module cbcc_queue #(
  parameter int unsigned DEPTH = cbcc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cbcc_pkg::cmd_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output cbcc_pkg::cmd_entry_t head_entry
);

  `include "config_bitstream_crc16_check_top_defines.svh"

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cbcc_pkg::cmd_entry_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_entry = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CBCC_ASSERT(a_no_push_full, clk, rst_n, push |-> !full, "push into a full queue")
  `CBCC_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> head_valid, "pop from an empty queue")

endmodule

// ===== design/cbcc_back.sv =====
module cbcc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  cbcc_pkg::cmd_entry_t         head_entry,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cbcc_pkg::kind_t              out_kind,
  output logic [cbcc_pkg::CRC_W-1:0]   out_crc,
  output logic [cbcc_pkg::WORD_W-1:0]  out_expected
);

  `include "config_bitstream_crc16_check_top_defines.svh"

  logic [cbcc_pkg::CRC_W-1:0]  crc_r, crc_nxt;
  logic                        out_valid_r, out_valid_nxt;
  cbcc_pkg::kind_t             kind_r, kind_nxt;
  logic [cbcc_pkg::CRC_W-1:0]  res_crc_r, res_crc_nxt;
  logic [cbcc_pkg::WORD_W-1:0] expected_r, expected_nxt;
  logic [cbcc_pkg::CRC_W-1:0]  folded;
  logic                        reports;

  assign folded  = cbcc_pkg::crc_fold(crc_r, head_entry.word, head_entry.addr);
  assign reports = (head_entry.cmd == cbcc_pkg::CMD_CHECK) ||
                   (head_entry.cmd == cbcc_pkg::CMD_FOLD_AUTO);
  // Commands without a result never wait on the output register.
  assign pop = head_valid && (!reports || !out_valid_r || out_ready);

  always_comb begin
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    res_crc_nxt   = res_crc_r;
    expected_nxt  = expected_r;
    if (pop) begin
      case (head_entry.cmd)
        cbcc_pkg::CMD_FOLD: begin
          crc_nxt = folded;
        end
        cbcc_pkg::CMD_FOLD_AUTO: begin
          crc_nxt       = '0;
          out_valid_nxt = 1'b1;
          kind_nxt      = cbcc_pkg::KIND_AUTO;
          res_crc_nxt   = cbcc_pkg::reflect16(folded);
          expected_nxt  = '0;
        end
        cbcc_pkg::CMD_CHECK: begin
          crc_nxt       = '0;
          out_valid_nxt = 1'b1;
          kind_nxt      = cbcc_pkg::KIND_CHECK;
          res_crc_nxt   = cbcc_pkg::reflect16(crc_r);
          expected_nxt  = head_entry.word;
        end
        cbcc_pkg::CMD_CLEAR: begin
          crc_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    res_crc_r  <= res_crc_nxt;
    expected_r <= expected_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_crc      = res_crc_r;
  assign out_expected = expected_r;

  `CBCC_ASSERT(a_crc_cleared, clk, rst_n, (pop && head_entry.cmd != cbcc_pkg::CMD_FOLD) |=> (crc_r == '0), "CRC not cleared after a check, clear or automatic report")
  `CBCC_ASSERT(a_report_loads, clk, rst_n, (pop && reports) |=> out_valid_r, "reporting command left no result")

endmodule

// ===== design/config_bitstream_crc16_check_top.sv =====
// Configuration CRC-16 checker (poly 0x8005, init 0, result bit-reflected). It takes
// one beat per cycle while in_tready is high: headers and payload words of write
// packets. A front stage tracks packets and sends only the words that touch the CRC
// through a short command queue to a back stage, which folds the whole 37-bit
// word-plus-address update combinationally and holds each report in an output register.
// A report is registered in a queue entry and then in the output register. When a report
// waits on out_tready the queue absorbs QUEUE_DEPTH commands before in_tready drops.
module config_bitstream_crc16_check_top #(
  parameter int unsigned QUEUE_DEPTH = cbcc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // reg_address[4:0], word_count[31:5], data_word[63:32]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // computed_crc[15:0], expected_crc[47:16]
  output logic [0:0]  out_tuser   // report_kind[0]
);

  logic                 accept;
  logic                 push;
  cbcc_pkg::cmd_entry_t push_entry;
  logic                 full;
  logic                 pop;
  logic                 head_valid;
  cbcc_pkg::cmd_entry_t head_entry;
  cbcc_pkg::kind_t      kind;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  cbcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (accept),
    .op          (cbcc_pkg::op_t'(in_tuser)),
    .reg_address (in_tdata[4:0]),
    .word_count  (in_tdata[31:5]),
    .data_word   (in_tdata[63:32]),
    .push        (push),
    .push_entry  (push_entry)
  );

  cbcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  cbcc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (kind),
    .out_crc      (out_tdata[15:0]),
    .out_expected (out_tdata[47:16])
  );

  assign out_tuser = kind;

endmodule
